FILE: design/x86ild_pkg.sv
// shared constants and decode helpers for the x86 instruction length decoder
// no dependencies

package x86ild_pkg;

    localparam logic [3:0] MAX_INSN_BYTES = 4'd15;

    localparam logic [7:0] PFX_LOCK  = 8'hF0;
    localparam logic [7:0] PFX_REPNE = 8'hF2;
    localparam logic [7:0] PFX_REP   = 8'hF3;
    localparam logic [7:0] PFX_OPSZ  = 8'h66;
    localparam logic [7:0] PFX_ADSZ  = 8'h67;
    localparam logic [7:0] PFX_FS    = 8'h64;
    localparam logic [7:0] PFX_GS    = 8'h65;
    localparam logic [7:0] SEG_MASK  = 8'hE7;
    localparam logic [7:0] SEG_MATCH = 8'h26;
    localparam logic [3:0] REX_HIGH  = 4'h4;

    localparam logic [7:0] HDR_EVEX  = 8'h62;
    localparam logic [7:0] HDR_VEX3  = 8'hC4;
    localparam logic [7:0] HDR_VEX2  = 8'hC5;
    localparam logic [2:0] SKIP_EVEX = 3'd3;
    localparam logic [2:0] SKIP_VEX3 = 3'd2;
    localparam logic [2:0] SKIP_VEX2 = 3'd1;

    localparam logic [7:0] OP_ESC        = 8'h0F;
    localparam logic [7:0] OP_ESC38      = 8'h38;
    localparam logic [7:0] OP_ESC3A      = 8'h3A;
    localparam logic [7:0] OP_CALL       = 8'hE8;
    localparam logic [7:0] OP_JMP        = 8'hE9;
    localparam logic [7:0] OP_GRP5       = 8'hFF;
    localparam logic [7:0] OP_MOVIMM     = 8'hC7;
    localparam logic [7:0] OP_ADD_MR     = 8'h01;
    localparam logic [7:0] OP_ADD_RM     = 8'h03;
    localparam logic [7:0] OP_SUB_MR     = 8'h29;
    localparam logic [7:0] OP_SUB_RM     = 8'h2B;
    localparam logic [7:0] OP_MOV_ST8    = 8'h88;
    localparam logic [7:0] OP_MOV_ST     = 8'h89;
    localparam logic [7:0] OP_MOV_LD8    = 8'h8A;
    localparam logic [7:0] OP_MOV_LD     = 8'h8B;
    localparam logic [7:0] OP_MOVR_FIRST = 8'hB8;
    localparam logic [7:0] OP_MOVR_LAST  = 8'hBF;

    localparam logic [1:0] MOD_REG   = 2'd3;
    localparam logic [2:0] RM_SIB    = 3'd4;
    localparam logic [2:0] RM_DISP32 = 3'd5;
    localparam logic [2:0] REG_CALLN = 3'd2;
    localparam logic [2:0] REG_CALLF = 3'd3;

    localparam int FL_MODRM = 0;
    localparam int FL_SIB   = 1;
    localparam int FL_REXW  = 2;
    localparam int FL_VEX   = 3;
    localparam int FL_EVEX  = 4;
    localparam int FL_IP    = 5;
    localparam int FL_MEM   = 6;

    typedef logic [6:0] form_flags_t;

    function automatic logic legacy_prefix(input logic [7:0] b);
        return b == PFX_LOCK || b == PFX_REPNE || b == PFX_REP || b == PFX_OPSZ ||
               b == PFX_ADSZ || (b & SEG_MASK) == SEG_MATCH || b == PFX_FS ||
               b == PFX_GS;
    endfunction

    function automatic logic takes_modrm(input logic [7:0] op);
        return (op >= OP_MOV_ST8 && op <= OP_MOV_LD) || op == OP_GRP5 ||
               op == OP_ADD_MR || op == OP_ADD_RM || op == OP_SUB_MR ||
               op == OP_SUB_RM;
    endfunction

    function automatic logic [3:0] imm_bytes(input logic [7:0] op, input logic rex_w);
        logic [3:0] n;
        n = 4'd0;
        if (op >= OP_MOVR_FIRST && op <= OP_MOVR_LAST) begin
            n = rex_w ? 4'd8 : 4'd4;
        end else if (op == OP_MOVIMM || op == OP_CALL || op == OP_JMP) begin
            n = 4'd4;
        end
        return n;
    endfunction

    function automatic logic [3:0] disp_bytes(input logic [7:0] modrm, input logic [7:0] sib);
        logic [3:0] n;
        n = 4'd0;
        case (modrm[7:6])
            2'd1: begin
                n = 4'd1;
            end
            2'd2: begin
                n = 4'd4;
            end
            2'd0: begin
                if (modrm[2:0] == RM_DISP32) begin
                    n = 4'd4;
                end else if (modrm[2:0] == RM_SIB && sib[2:0] == RM_DISP32) begin
                    n = 4'd4;
                end
            end
            default: begin
                n = 4'd0;
            end
        endcase
        return n;
    endfunction

endpackage

FILE: design/x86_instruction_length_decoder.sv
// x86-64 instruction length decoder, one code byte per word
// depends on x86ild_pkg

// Usage:
// s_ channel: one code byte per word; s_first_byte marks the first byte of an
// instruction and s_insn_address is sampled with it. A first byte during an
// instruction abandons it. Bytes without a start mark while idle are dropped.
// m_ channel: one word per finished instruction, carrying its length, opcode
// bytes, ModR/M, SIB, flags, displacement, immediate and branch target. If the
// fifteenth byte does not finish an instruction, a word with status 1 and
// length 15 is sent and the decoder waits for the next start mark.
// Timing: a byte is held in the input register, then decoded combinationally into
// the result register; the result of an instruction shows on m_ once its last byte
// has passed through both registers. One byte per cycle is taken sustained while
// m_ is not stalled; the per-byte parse state update plus the 64-bit target adder
// is the critical path.
// Stall: while m_ready is low a pending result holds; one more byte may wait
// in the input register, after which s_ready drops.
// Reset: aresetn (synchronous, active low) empties both registers and puts
// the parser in idle.

module x86_instruction_length_decoder (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_code_byte,
    input  logic               s_first_byte,
    input  logic [63:0]        s_insn_address,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_status,
    output logic [3:0]         m_length,
    output logic [23:0]        m_opcode_bytes,
    output logic [1:0]         m_opcode_count,
    output logic [7:0]         m_modrm_byte,
    output logic [7:0]         m_sib_byte,
    output logic [6:0]         m_form_flags,
    output logic signed [31:0] m_displacement,
    output logic [63:0]        m_immediate,
    output logic [63:0]        m_branch_target
);

    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_PREFIX = 4'd1;
    localparam logic [3:0] PH_SKIP   = 4'd2;
    localparam logic [3:0] PH_OPC    = 4'd3;
    localparam logic [3:0] PH_OP2    = 4'd4;
    localparam logic [3:0] PH_OP3    = 4'd5;
    localparam logic [3:0] PH_MODRM  = 4'd6;
    localparam logic [3:0] PH_SIB    = 4'd7;
    localparam logic [3:0] PH_DISP   = 4'd8;
    localparam logic [3:0] PH_IMM    = 4'd9;

    // input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_first_reg;
    logic [63:0] in_addr_reg;

    // parse state
    logic [3:0]             phase_reg, phase_next;
    logic [3:0]             count_reg, count_next;
    logic [2:0]             skip_reg, skip_next;
    logic [3:0]             field_reg, field_next;
    logic [23:0]            opc_reg, opc_next;
    logic [1:0]             opcnt_reg, opcnt_next;
    logic [7:0]             mrm_reg, mrm_next;
    logic [7:0]             sib_reg, sib_next;
    x86ild_pkg::form_flags_t flags_reg, flags_next;
    logic [31:0]            disp_reg, disp_next;
    logic [63:0]            imm_reg, imm_next;
    logic [63:0]            addr_reg, addr_next;

    // result register
    logic        m_valid_reg;
    logic        status_reg;
    logic [3:0]  length_reg;
    logic [23:0] res_opc_reg;
    logic [1:0]  res_opcnt_reg;
    logic [7:0]  res_mrm_reg;
    logic [7:0]  res_sib_reg;
    logic [6:0]  res_flags_reg;
    logic [31:0] res_disp_reg;
    logic [63:0] res_imm_reg;
    logic [63:0] target_reg;

    logic        out_free;
    logic        proc_go;
    logic        active;
    logic        done;
    logic        overlong;
    logic        go_op1;
    logic        go_after;
    logic        go_disp;
    logic        go_imm;
    logic [3:0]  dsz;
    logic [3:0]  isz;
    logic [1:0]  kd;
    logic [2:0]  ki;
    logic [7:0]  b;
    logic [63:0] target;

    assign out_free = !m_valid_reg || m_ready;
    assign proc_go  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        skip_next  = skip_reg;
        field_next = field_reg;
        opc_next   = opc_reg;
        opcnt_next = opcnt_reg;
        mrm_next   = mrm_reg;
        sib_next   = sib_reg;
        flags_next = flags_reg;
        disp_next  = disp_reg;
        imm_next   = imm_reg;
        addr_next  = addr_reg;
        active     = 1'b0;
        done       = 1'b0;
        overlong   = 1'b0;
        go_op1     = 1'b0;
        go_after   = 1'b0;
        go_disp    = 1'b0;
        go_imm     = 1'b0;
        dsz        = 4'd0;
        isz        = 4'd0;
        kd         = 2'd0;
        ki         = 3'd0;
        target     = 64'd0;
        b          = in_byte_reg;

        if (in_first_reg) begin
            count_next = 4'd0;
            skip_next  = 3'd0;
            field_next = 4'd0;
            opc_next   = 24'd0;
            opcnt_next = 2'd0;
            mrm_next   = 8'd0;
            sib_next   = 8'd0;
            flags_next = '0;
            disp_next  = 32'd0;
            imm_next   = 64'd0;
            addr_next  = in_addr_reg;
            phase_next = PH_PREFIX;
            active     = 1'b1;
        end else if (phase_reg != PH_IDLE) begin
            active = 1'b1;
        end

        if (active) begin
            count_next = count_next + 4'd1;
            case (phase_next)
                PH_PREFIX: begin
                    if (x86ild_pkg::legacy_prefix(b)) begin
                        flags_next[x86ild_pkg::FL_REXW] = 1'b0;
                    end else if (b[7:4] == x86ild_pkg::REX_HIGH) begin
                        flags_next[x86ild_pkg::FL_REXW] = b[3];
                    end else if (b == x86ild_pkg::HDR_EVEX) begin
                        flags_next[x86ild_pkg::FL_EVEX] = 1'b1;
                        skip_next  = x86ild_pkg::SKIP_EVEX;
                        phase_next = PH_SKIP;
                    end else if (b == x86ild_pkg::HDR_VEX3) begin
                        flags_next[x86ild_pkg::FL_VEX] = 1'b1;
                        skip_next  = x86ild_pkg::SKIP_VEX3;
                        phase_next = PH_SKIP;
                    end else if (b == x86ild_pkg::HDR_VEX2) begin
                        flags_next[x86ild_pkg::FL_VEX] = 1'b1;
                        skip_next  = x86ild_pkg::SKIP_VEX2;
                        phase_next = PH_SKIP;
                    end else begin
                        go_op1 = 1'b1;
                    end
                end
                PH_SKIP: begin
                    if (skip_next != 3'd0) begin
                        skip_next = skip_next - 3'd1;
                    end
                    if (skip_next == 3'd0) begin
                        phase_next = PH_OPC;
                    end
                end
                PH_OPC: begin
                    go_op1 = 1'b1;
                end
                PH_OP2: begin
                    opc_next[15:8] = b;
                    opcnt_next     = 2'd2;
                    if (b == x86ild_pkg::OP_ESC38 || b == x86ild_pkg::OP_ESC3A) begin
                        phase_next = PH_OP3;
                    end else begin
                        go_after = 1'b1;
                    end
                end
                PH_OP3: begin
                    opc_next[23:16] = b;
                    opcnt_next      = 2'd3;
                    go_after        = 1'b1;
                end
                PH_MODRM: begin
                    mrm_next = b;
                    flags_next[x86ild_pkg::FL_MODRM] = 1'b1;
                    if (b[7:6] != x86ild_pkg::MOD_REG && b[2:0] == x86ild_pkg::RM_SIB) begin
                        phase_next = PH_SIB;
                    end else begin
                        go_disp = 1'b1;
                    end
                end
                PH_SIB: begin
                    sib_next = b;
                    flags_next[x86ild_pkg::FL_SIB] = 1'b1;
                    go_disp = 1'b1;
                end
                PH_DISP: begin
                    dsz = x86ild_pkg::disp_bytes(mrm_next, sib_next);
                    kd  = 2'(dsz - field_next);
                    disp_next[{kd, 3'b000} +: 8] = disp_next[{kd, 3'b000} +: 8] | b;
                    field_next = field_next - 4'd1;
                    if (field_next == 4'd0) begin
                        if (dsz == 4'd1 && disp_next[7]) begin
                            disp_next[31:8] = 24'hFFFFFF;
                        end
                        go_imm = 1'b1;
                    end
                end
                PH_IMM: begin
                    isz = x86ild_pkg::imm_bytes(opc_next[7:0], flags_next[x86ild_pkg::FL_REXW]);
                    ki  = 3'(isz - field_next);
                    imm_next[{ki, 3'b000} +: 8] = imm_next[{ki, 3'b000} +: 8] | b;
                    field_next = field_next - 4'd1;
                    done = (field_next == 4'd0);
                end
                default: begin
                end
            endcase

            if (go_op1) begin
                opc_next   = {16'd0, b};
                opcnt_next = 2'd1;
                if (b == x86ild_pkg::OP_ESC) begin
                    phase_next = PH_OP2;
                end else begin
                    go_after = 1'b1;
                end
            end
            if (go_after) begin
                if (x86ild_pkg::takes_modrm(opc_next[7:0])) begin
                    phase_next = PH_MODRM;
                end else begin
                    go_imm = 1'b1;
                end
            end
            if (go_disp) begin
                dsz = x86ild_pkg::disp_bytes(mrm_next, sib_next);
                if (dsz == 4'd0) begin
                    go_imm = 1'b1;
                end else begin
                    field_next = dsz;
                    phase_next = PH_DISP;
                end
            end
            if (go_imm) begin
                isz = x86ild_pkg::imm_bytes(opc_next[7:0], flags_next[x86ild_pkg::FL_REXW]);
                if (isz == 4'd0) begin
                    done = 1'b1;
                end else begin
                    field_next = isz;
                    phase_next = PH_IMM;
                end
            end

            if (done) begin
                if (opc_next[7:0] == x86ild_pkg::OP_CALL || opc_next[7:0] == x86ild_pkg::OP_JMP) begin
                    flags_next[x86ild_pkg::FL_IP] = 1'b1;
                    target = addr_next + {60'd0, count_next} +
                             {{32{imm_next[31]}}, imm_next[31:0]};
                end
                if (opc_next[7:0] == x86ild_pkg::OP_GRP5 && flags_next[x86ild_pkg::FL_MODRM] &&
                    (mrm_next[5:3] == x86ild_pkg::REG_CALLN ||
                     mrm_next[5:3] == x86ild_pkg::REG_CALLF)) begin
                    flags_next[x86ild_pkg::FL_IP] = 1'b1;
                    if (mrm_next[7:6] != x86ild_pkg::MOD_REG) begin
                        flags_next[x86ild_pkg::FL_MEM] = 1'b1;
                        target = {{32{disp_next[31]}}, disp_next};
                    end
                end
                phase_next = PH_IDLE;
            end else if (count_next == x86ild_pkg::MAX_INSN_BYTES) begin
                overlong   = 1'b1;
                phase_next = PH_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            phase_reg    <= PH_IDLE;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (proc_go) begin
                phase_reg <= phase_next;
            end
            if (proc_go && (done || overlong)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg  <= s_code_byte;
            in_first_reg <= s_first_byte;
            in_addr_reg  <= s_insn_address;
        end
        if (proc_go) begin
            count_reg <= count_next;
            skip_reg  <= skip_next;
            field_reg <= field_next;
            opc_reg   <= opc_next;
            opcnt_reg <= opcnt_next;
            mrm_reg   <= mrm_next;
            sib_reg   <= sib_next;
            flags_reg <= flags_next;
            disp_reg  <= disp_next;
            imm_reg   <= imm_next;
            addr_reg  <= addr_next;
        end
        if (proc_go && (done || overlong)) begin
            status_reg    <= overlong;
            length_reg    <= overlong ? x86ild_pkg::MAX_INSN_BYTES : count_next;
            res_opc_reg   <= overlong ? 24'd0 : opc_next;
            res_opcnt_reg <= overlong ? 2'd0 : opcnt_next;
            res_mrm_reg   <= overlong ? 8'd0 : mrm_next;
            res_sib_reg   <= overlong ? 8'd0 : sib_next;
            res_flags_reg <= overlong ? 7'd0 : flags_next;
            res_disp_reg  <= overlong ? 32'd0 : disp_next;
            res_imm_reg   <= overlong ? 64'd0 : imm_next;
            target_reg    <= overlong ? 64'd0 : target;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_length        = length_reg;
    assign m_opcode_bytes  = res_opc_reg;
    assign m_opcode_count  = res_opcnt_reg;
    assign m_modrm_byte    = res_mrm_reg;
    assign m_sib_byte      = res_sib_reg;
    assign m_form_flags    = res_flags_reg;
    assign m_displacement  = res_disp_reg;
    assign m_immediate     = res_imm_reg;
    assign m_branch_target = target_reg;

`ifndef SYNTHESIS
    a_overlong_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> m_length == x86ild_pkg::MAX_INSN_BYTES &&
        m_form_flags == 7'd0 && m_opcode_count == 2'd0)
        else $error("overlong word carries decode fields");

    a_decoded_has_opcode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_status |-> m_opcode_count != 2'd0 && m_length != 4'd0)
        else $error("decoded word without opcode");

    a_mem_target_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_form_flags[x86ild_pkg::FL_MEM] |->
        m_form_flags[x86ild_pkg::FL_IP] && m_form_flags[x86ild_pkg::FL_MODRM])
        else $error("memory target without modrm branch form");

    a_sib_needs_modrm: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_form_flags[x86ild_pkg::FL_SIB] |-> m_form_flags[x86ild_pkg::FL_MODRM])
        else $error("sib flagged without modrm");

    a_stall_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && m_valid_reg && !m_ready)
        else $error("input blocked without a stalled result");
`endif

endmodule

FILE: sim/x86_instruction_length_decoder_tb.sv
// self-checking testbench for x86_instruction_length_decoder: streams code bytes,
// predicts every decoded instruction word and compares it field by field
// depends on x86ild_pkg and the decoder rtl
`timescale 1ns / 1ps

module x86_instruction_length_decoder_tb;

    localparam logic [7:0] OP_NOP        = 8'h90;
    localparam logic [7:0] OP_RET        = 8'hC3;
    localparam logic [7:0] SEG_ES        = 8'h26;
    localparam logic [7:0] SEG_CS        = 8'h2E;
    localparam logic [7:0] SEG_SS        = 8'h36;
    localparam logic [7:0] SEG_DS        = 8'h3E;
    localparam logic [7:0] REX_BARE      = 8'h40;
    localparam logic [7:0] REX_WIDE      = 8'h48;
    localparam logic [7:0] REX_FULL      = 8'h4F;
    localparam int         BYTE_TARGET   = 1350;
    localparam int         DIR_ROWS      = 26;

    typedef enum logic [3:0] {
        P_IDLE, P_PREFIX, P_SKIP, P_OPC, P_OP2, P_OP3, P_MODRM, P_SIB, P_DISP, P_IMM
    } parse_phase_t;

    typedef enum logic [1:0] {ROW_PREDICTED, ROW_SHORT, ROW_OVERLONG} row_check_t;

    typedef struct packed {
        logic                    status;
        logic [3:0]              len;
        logic [23:0]             opc;
        logic [1:0]              opc_n;
        logic [7:0]              modrm;
        logic [7:0]              sib;
        x86ild_pkg::form_flags_t flags;
        logic [31:0]             disp;
        logic [63:0]             imm;
        logic [63:0]             target;
    } insn_result_t;

    typedef struct packed {
        logic [7:0]  code;
        logic        first;
        logic [63:0] addr;
        row_check_t  chk;
        logic [3:0]  want_len;
        logic [7:0]  want_op;
    } stim_row_t;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [7:0]         s_code_byte;
    logic               s_first_byte;
    logic [63:0]        s_insn_address;
    logic               m_valid;
    logic               m_ready;
    logic               m_status;
    logic [3:0]         m_length;
    logic [23:0]        m_opcode_bytes;
    logic [1:0]         m_opcode_count;
    logic [7:0]         m_modrm_byte;
    logic [7:0]         m_sib_byte;
    logic [6:0]         m_form_flags;
    logic signed [31:0] m_displacement;
    logic [63:0]        m_immediate;
    logic [63:0]        m_branch_target;

    // decoder shadow state
    parse_phase_t            dec_phase;
    int                      dec_bytes;
    int                      dec_skip;
    int                      dec_field;
    logic [23:0]             dec_opcode;
    logic [1:0]              dec_opcode_n;
    logic [7:0]              dec_modrm;
    logic [7:0]              dec_sib;
    x86ild_pkg::form_flags_t dec_flags;
    logic [31:0]             dec_disp;
    logic [63:0]             dec_imm;
    logic [63:0]             dec_addr;

    insn_result_t decoded_insns [$];
    insn_result_t head_insn;
    int           fail_count = 0;
    int           bytes_sent = 0;
    int           src_idle_pct = 27;
    int           sink_idle_pct = 27;
    bit           hold_pending = 1'b0;
    int           hold_left = 0;

    logic [7:0] prefix_pool [11] = '{
        x86ild_pkg::PFX_LOCK, x86ild_pkg::PFX_REPNE, x86ild_pkg::PFX_REP,
        x86ild_pkg::PFX_OPSZ, x86ild_pkg::PFX_ADSZ, SEG_ES, SEG_CS, SEG_SS, SEG_DS,
        x86ild_pkg::PFX_FS, x86ild_pkg::PFX_GS
    };
    logic [7:0] modrm_pool [9] = '{
        x86ild_pkg::OP_ADD_MR, x86ild_pkg::OP_ADD_RM, x86ild_pkg::OP_SUB_MR,
        x86ild_pkg::OP_SUB_RM, x86ild_pkg::OP_MOV_ST8, x86ild_pkg::OP_MOV_ST,
        x86ild_pkg::OP_MOV_LD8, x86ild_pkg::OP_MOV_LD, x86ild_pkg::OP_GRP5
    };

    stim_row_t dir_rows [DIR_ROWS] = '{
        '{8'h00, 1'b0, 64'h0, ROW_PREDICTED, 4'd0, 8'h00},
        '{OP_NOP, 1'b1, 64'h0, ROW_SHORT, 4'd1, OP_NOP},
        '{x86ild_pkg::PFX_OPSZ, 1'b1, 64'h1000, ROW_PREDICTED, 4'd0, 8'h00},
        '{OP_RET, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, ROW_SHORT, 4'd1, OP_RET},
        '{REX_WIDE, 1'b1, 64'h8000_0000_0000_0000, ROW_PREDICTED, 4'd0, 8'h00},
        '{x86ild_pkg::PFX_LOCK, 1'b0, 64'h0, ROW_PREDICTED, 4'd0, 8'h00},
        '{x86ild_pkg::PFX_REPNE, 1'b0, 64'h0, ROW_PREDICTED, 4'd0, 8'h00},
        '{x86ild_pkg::PFX_REP, 1'b0, 64'h0, ROW_PREDICTED, 4'd0, 8'h00},
        '{x86ild_pkg::PFX_OPSZ, 1'b0, 64'h0, ROW_PREDICTED, 4'd0, 8'h00},
        '{x86ild_pkg::PFX_ADSZ, 1'b0, 64'h0, ROW_PREDICTED, 4'd0, 8'h00},
        '{SEG_ES, 1'b0, 64'h0, ROW_PREDICTED, 4'd0, 8'h00},
        '{SEG_CS, 1'b0, 64'h0, ROW_PREDICTED, 4'd0, 8'h00},
        '{SEG_SS, 1'b0, 64'h0, ROW_PREDICTED, 4'd0, 8'h00},
        '{SEG_DS, 1'b0, 64'h0, ROW_PREDICTED, 4'd0, 8'h00},
        '{x86ild_pkg::PFX_FS, 1'b0, 64'h0, ROW_PREDICTED, 4'd0, 8'h00},
        '{x86ild_pkg::PFX_GS, 1'b0, 64'h0, ROW_PREDICTED, 4'd0, 8'h00},
        '{REX_BARE, 1'b0, 64'h0, ROW_PREDICTED, 4'd0, 8'h00},
        '{REX_FULL, 1'b0, 64'h0, ROW_PREDICTED, 4'd0, 8'h00},
        '{x86ild_pkg::OP_ESC, 1'b0, 64'h0, ROW_OVERLONG, 4'd0, 8'h00},
        '{x86ild_pkg::OP_CALL, 1'b1, 64'hFFFF_FFFF_FFFF_FFF0, ROW_PREDICTED, 4'd0, 8'h00},
        '{8'h00, 1'b0, 64'h0, ROW_PREDICTED, 4'd0, 8'h00},
        '{8'h00, 1'b0, 64'h0, ROW_PREDICTED, 4'd0, 8'h00},
        '{8'h00, 1'b0, 64'h0, ROW_PREDICTED, 4'd0, 8'h00},
        '{8'h80, 1'b0, 64'h0, ROW_PREDICTED, 4'd0, 8'h00},
        '{x86ild_pkg::OP_GRP5, 1'b1, 64'h0, ROW_PREDICTED, 4'd0, 8'h00},
        '{8'hD0, 1'b0, 64'h0, ROW_PREDICTED, 4'd0, 8'h00}
    };

    x86_instruction_length_decoder i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_code_byte    (s_code_byte),
        .s_first_byte   (s_first_byte),
        .s_insn_address (s_insn_address),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_length       (m_length),
        .m_opcode_bytes (m_opcode_bytes),
        .m_opcode_count (m_opcode_count),
        .m_modrm_byte   (m_modrm_byte),
        .m_sib_byte     (m_sib_byte),
        .m_form_flags   (m_form_flags),
        .m_displacement (m_displacement),
        .m_immediate    (m_immediate),
        .m_branch_target(m_branch_target)
    );

    always #5 aclk = ~aclk;

    function automatic bit is_legacy_prefix(input logic [7:0] b);
        case (b)
            x86ild_pkg::PFX_LOCK, x86ild_pkg::PFX_REPNE, x86ild_pkg::PFX_REP,
            x86ild_pkg::PFX_OPSZ, x86ild_pkg::PFX_ADSZ, x86ild_pkg::PFX_FS,
            x86ild_pkg::PFX_GS: return 1'b1;
            default: return (b & x86ild_pkg::SEG_MASK) == x86ild_pkg::SEG_MATCH;
        endcase
    endfunction

    function automatic bit needs_modrm(input logic [7:0] op);
        case (op)
            x86ild_pkg::OP_ADD_MR, x86ild_pkg::OP_ADD_RM, x86ild_pkg::OP_SUB_MR,
            x86ild_pkg::OP_SUB_RM, x86ild_pkg::OP_MOV_ST8, x86ild_pkg::OP_MOV_ST,
            x86ild_pkg::OP_MOV_LD8, x86ild_pkg::OP_MOV_LD, x86ild_pkg::OP_GRP5: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic int imm_len(input logic [7:0] op, input logic wide);
        if (op >= x86ild_pkg::OP_MOVR_FIRST && op <= x86ild_pkg::OP_MOVR_LAST) begin
            return wide ? 8 : 4;
        end
        if (op == x86ild_pkg::OP_MOVIMM || op == x86ild_pkg::OP_CALL ||
            op == x86ild_pkg::OP_JMP) begin
            return 4;
        end
        return 0;
    endfunction

    function automatic int disp_len();
        case (dec_modrm[7:6])
            2'd1: return 1;
            2'd2: return 4;
            2'd0: begin
                if (dec_modrm[2:0] == x86ild_pkg::RM_DISP32) begin
                    return 4;
                end
                return (dec_modrm[2:0] == x86ild_pkg::RM_SIB &&
                        dec_sib[2:0] == x86ild_pkg::RM_DISP32) ? 4 : 0;
            end
            default: return 0;
        endcase
    endfunction

    function automatic void clear_insn_fields();
        dec_bytes = 0;
        dec_skip = 0;
        dec_field = 0;
        dec_opcode = '0;
        dec_opcode_n = '0;
        dec_modrm = '0;
        dec_sib = '0;
        dec_flags = '0;
        dec_disp = '0;
        dec_imm = '0;
    endfunction

    // each returns 1 when the instruction is complete
    function automatic bit start_imm();
        int n;
        n = imm_len(dec_opcode[7:0], dec_flags[x86ild_pkg::FL_REXW]);
        if (n == 0) begin
            return 1'b1;
        end
        dec_field = n;
        dec_phase = P_IMM;
        return 1'b0;
    endfunction

    function automatic bit start_disp();
        int n;
        n = disp_len();
        if (n == 0) begin
            return start_imm();
        end
        dec_field = n;
        dec_phase = P_DISP;
        return 1'b0;
    endfunction

    function automatic bit after_opcode();
        if (needs_modrm(dec_opcode[7:0])) begin
            dec_phase = P_MODRM;
            return 1'b0;
        end
        return start_imm();
    endfunction

    function automatic bit take_first_opcode(input logic [7:0] b);
        dec_opcode = {16'h0, b};
        dec_opcode_n = 2'd1;
        if (b == x86ild_pkg::OP_ESC) begin
            dec_phase = P_OP2;
            return 1'b0;
        end
        return after_opcode();
    endfunction

    task automatic decode_byte(input logic [7:0] b, input logic first, input logic [63:0] addr);
        bit           done;
        int           total;
        int           k;
        logic [63:0]  target;
        insn_result_t r;
        if (first) begin
            clear_insn_fields();
            dec_addr = addr;
            dec_phase = P_PREFIX;
        end else if (dec_phase == P_IDLE) begin
            return;
        end
        dec_bytes++;
        done = 1'b0;
        case (dec_phase)
            P_PREFIX: begin
                if (is_legacy_prefix(b)) begin
                    dec_flags[x86ild_pkg::FL_REXW] = 1'b0;
                end else if (b[7:4] == x86ild_pkg::REX_HIGH) begin
                    dec_flags[x86ild_pkg::FL_REXW] = b[3];
                end else if (b == x86ild_pkg::HDR_EVEX) begin
                    dec_flags[x86ild_pkg::FL_EVEX] = 1'b1;
                    dec_skip = int'(x86ild_pkg::SKIP_EVEX);
                    dec_phase = P_SKIP;
                end else if (b == x86ild_pkg::HDR_VEX3) begin
                    dec_flags[x86ild_pkg::FL_VEX] = 1'b1;
                    dec_skip = int'(x86ild_pkg::SKIP_VEX3);
                    dec_phase = P_SKIP;
                end else if (b == x86ild_pkg::HDR_VEX2) begin
                    dec_flags[x86ild_pkg::FL_VEX] = 1'b1;
                    dec_skip = int'(x86ild_pkg::SKIP_VEX2);
                    dec_phase = P_SKIP;
                end else begin
                    done = take_first_opcode(b);
                end
            end
            P_SKIP: begin
                if (dec_skip > 0) begin
                    dec_skip--;
                end
                if (dec_skip == 0) begin
                    dec_phase = P_OPC;
                end
            end
            P_OPC: begin
                done = take_first_opcode(b);
            end
            P_OP2: begin
                dec_opcode[15:8] = b;
                dec_opcode_n = 2'd2;
                if (b == x86ild_pkg::OP_ESC38 || b == x86ild_pkg::OP_ESC3A) begin
                    dec_phase = P_OP3;
                end else begin
                    done = after_opcode();
                end
            end
            P_OP3: begin
                dec_opcode[23:16] = b;
                dec_opcode_n = 2'd3;
                done = after_opcode();
            end
            P_MODRM: begin
                dec_modrm = b;
                dec_flags[x86ild_pkg::FL_MODRM] = 1'b1;
                if (b[7:6] != x86ild_pkg::MOD_REG && b[2:0] == x86ild_pkg::RM_SIB) begin
                    dec_phase = P_SIB;
                end else begin
                    done = start_disp();
                end
            end
            P_SIB: begin
                dec_sib = b;
                dec_flags[x86ild_pkg::FL_SIB] = 1'b1;
                done = start_disp();
            end
            P_DISP: begin
                total = disp_len();
                k = (total - dec_field) & 3;
                dec_disp[8*k +: 8] = b;
                dec_field--;
                if (dec_field == 0) begin
                    if (total == 1 && dec_disp[7]) begin
                        dec_disp[31:8] = '1;
                    end
                    done = start_imm();
                end
            end
            P_IMM: begin
                total = imm_len(dec_opcode[7:0], dec_flags[x86ild_pkg::FL_REXW]);
                k = (total - dec_field) & 7;
                dec_imm[8*k +: 8] = b;
                dec_field--;
                done = (dec_field == 0);
            end
            default: begin
                done = 1'b0;
            end
        endcase
        r = '0;
        if (!done) begin
            if (dec_bytes < int'(x86ild_pkg::MAX_INSN_BYTES)) begin
                return;
            end
            r.status = 1'b1;
            r.len = x86ild_pkg::MAX_INSN_BYTES;
        end else begin
            target = '0;
            if (dec_opcode[7:0] == x86ild_pkg::OP_CALL ||
                dec_opcode[7:0] == x86ild_pkg::OP_JMP) begin
                dec_flags[x86ild_pkg::FL_IP] = 1'b1;
                target = dec_addr + 64'(dec_bytes) + {{32{dec_imm[31]}}, dec_imm[31:0]};
            end
            if (dec_opcode[7:0] == x86ild_pkg::OP_GRP5 && dec_flags[x86ild_pkg::FL_MODRM] &&
                (dec_modrm[5:3] == x86ild_pkg::REG_CALLN ||
                 dec_modrm[5:3] == x86ild_pkg::REG_CALLF)) begin
                dec_flags[x86ild_pkg::FL_IP] = 1'b1;
                if (dec_modrm[7:6] != x86ild_pkg::MOD_REG) begin
                    dec_flags[x86ild_pkg::FL_MEM] = 1'b1;
                    target = {{32{dec_disp[31]}}, dec_disp};
                end
            end
            r.len = 4'(dec_bytes);
            r.opc = dec_opcode;
            r.opc_n = dec_opcode_n;
            r.modrm = dec_modrm;
            r.sib = dec_sib;
            r.flags = dec_flags;
            r.disp = dec_disp;
            r.imm = dec_imm;
            r.target = target;
        end
        decoded_insns.push_back(r);
        dec_phase = P_IDLE;
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        fail_count++;
        $display("%0t: mismatch on %s, got %h, expected %h", $time, what, got, want);
    endtask

    function automatic logic [63:0] pick_address();
        case ($urandom_range(0, 7))
            0: return 64'h0;
            1: return '1;
            2: return 64'hFFFF_FFFF_FFFF_FF00 | 64'($urandom_range(0, 255));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic first, input logic [63:0] addr);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_code_byte <= b;
        s_first_byte <= first;
        s_insn_address <= addr;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        if (first || dec_phase != P_IDLE) begin
            bytes_sent++;
        end
        decode_byte(b, first, addr);
    endtask

    // well-formed instruction with random content, sometimes cut short by a restart
    task automatic send_random_instruction();
        logic [7:0]  plan [$];
        logic [7:0]  op;
        logic [2:0]  reg_f;
        logic [2:0]  rm;
        logic [63:0] addr;
        int          n_pfx;
        int          pick;
        int          idx;
        int          cut;
        n_pfx = ($urandom_range(0, 24) == 0) ? $urandom_range(10, 16) : $urandom_range(0, 3);
        repeat (n_pfx) begin
            if ($urandom_range(0, 2) == 0) begin
                plan.push_back(REX_BARE | 8'($urandom_range(0, 15)));
            end else begin
                plan.push_back(prefix_pool[$urandom_range(0, 10)]);
            end
        end
        case ($urandom_range(0, 7))
            0: begin
                plan.push_back(x86ild_pkg::HDR_EVEX);
                repeat (3) plan.push_back(8'($urandom_range(0, 255)));
            end
            1: begin
                plan.push_back(x86ild_pkg::HDR_VEX3);
                repeat (2) plan.push_back(8'($urandom_range(0, 255)));
            end
            2: begin
                plan.push_back(x86ild_pkg::HDR_VEX2);
                plan.push_back(8'($urandom_range(0, 255)));
            end
            default: begin
            end
        endcase
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1, 2: op = modrm_pool[$urandom_range(0, 8)];
            3: op = x86ild_pkg::OP_MOVR_FIRST + 8'($urandom_range(0, 7));
            4: op = x86ild_pkg::OP_MOVIMM;
            5: op = $urandom_range(0, 1) ? x86ild_pkg::OP_CALL : x86ild_pkg::OP_JMP;
            6: op = x86ild_pkg::OP_GRP5;
            7: op = x86ild_pkg::OP_ESC;
            default: op = 8'($urandom_range(0, 255));
        endcase
        plan.push_back(op);
        if (pick == 7) begin
            if ($urandom_range(0, 1)) begin
                plan.push_back($urandom_range(0, 1) ? x86ild_pkg::OP_ESC38
                                                    : x86ild_pkg::OP_ESC3A);
            end
            plan.push_back(8'($urandom_range(0, 255)));
        end else if (pick <= 2 || pick == 6) begin
            reg_f = 3'($urandom_range(0, 7));
            if (pick == 6 && $urandom_range(0, 1)) begin
                reg_f = $urandom_range(0, 1) ? x86ild_pkg::REG_CALLN : x86ild_pkg::REG_CALLF;
            end
            case ($urandom_range(0, 3))
                0: rm = x86ild_pkg::RM_SIB;
                1: rm = x86ild_pkg::RM_DISP32;
                default: rm = 3'($urandom_range(0, 7));
            endcase
            plan.push_back({2'($urandom_range(0, 3)), reg_f, rm});
            plan.push_back({5'($urandom_range(0, 31)),
                            ($urandom_range(0, 2) == 0) ? x86ild_pkg::RM_DISP32
                                                        : 3'($urandom_range(0, 7))});
        end
        addr = pick_address();
        cut = ($urandom_range(0, 11) == 0) ? $urandom_range(1, plan.size()) : 0;
        idx = 0;
        do begin
            send_byte(idx < plan.size() ? plan[idx] : 8'($urandom_range(0, 255)), idx == 0, addr);
            idx++;
        end while (dec_phase != P_IDLE && idx != cut);
    endtask

    // result side: random back-pressure plus one long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (decoded_insns.size() == 0) begin
                report_mismatch("word with nothing pending", 64'(m_length), 64'h0);
            end else begin
                head_insn = decoded_insns.pop_front();
                if (m_status !== head_insn.status)
                    report_mismatch("status", 64'(m_status), 64'(head_insn.status));
                if (m_length !== head_insn.len)
                    report_mismatch("length", 64'(m_length), 64'(head_insn.len));
                if (m_opcode_bytes !== head_insn.opc)
                    report_mismatch("opcode_bytes", 64'(m_opcode_bytes), 64'(head_insn.opc));
                if (m_opcode_count !== head_insn.opc_n)
                    report_mismatch("opcode_count", 64'(m_opcode_count),
                                    64'(head_insn.opc_n));
                if (m_modrm_byte !== head_insn.modrm)
                    report_mismatch("modrm_byte", 64'(m_modrm_byte), 64'(head_insn.modrm));
                if (m_sib_byte !== head_insn.sib)
                    report_mismatch("sib_byte", 64'(m_sib_byte), 64'(head_insn.sib));
                if (m_form_flags !== head_insn.flags)
                    report_mismatch("form_flags", 64'(m_form_flags), 64'(head_insn.flags));
                if (m_displacement !== head_insn.disp)
                    report_mismatch("displacement", 64'($unsigned(m_displacement)),
                                    64'(head_insn.disp));
                if (m_immediate !== head_insn.imm)
                    report_mismatch("immediate", m_immediate, head_insn.imm);
                if (m_branch_target !== head_insn.target)
                    report_mismatch("branch_target", m_branch_target, head_insn.target);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int           depth;
        insn_result_t typed;
        bit           hold_done;
        bit           drain_done;
        hold_done = 1'b0;
        drain_done = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_code_byte = '0;
        s_first_byte = 1'b0;
        s_insn_address = '0;
        clear_insn_fields();
        dec_phase = P_IDLE;
        dec_addr = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            depth = decoded_insns.size();
            send_byte(dir_rows[i].code, dir_rows[i].first, dir_rows[i].addr);
            if (dir_rows[i].chk != ROW_PREDICTED) begin
                typed = '0;
                if (dir_rows[i].chk == ROW_OVERLONG) begin
                    typed.status = 1'b1;
                    typed.len = x86ild_pkg::MAX_INSN_BYTES;
                end else begin
                    typed.len = dir_rows[i].want_len;
                    typed.opc = {16'h0, dir_rows[i].want_op};
                    typed.opc_n = 2'd1;
                end
                if (decoded_insns.size() > depth) begin
                    void'(decoded_insns.pop_back());
                end
                decoded_insns.push_back(typed);
            end
        end

        while (bytes_sent < BYTE_TARGET) begin
            if (!hold_done && bytes_sent >= 400) begin
                hold_done = 1'b1;
                hold_pending = 1'b1;
            end
            if (!drain_done && bytes_sent >= 900) begin
                drain_done = 1'b1;
                s_valid <= 1'b0;
                @(posedge aclk);
                while (decoded_insns.size() != 0) begin
                    @(posedge aclk);
                end
            end
            // no idling on either side for a while
            if (bytes_sent >= 1000 && bytes_sent < 1200) begin
                src_idle_pct = 0;
                sink_idle_pct = 0;
            end else begin
                src_idle_pct = 27;
                sink_idle_pct = 27;
            end
            if (dec_phase == P_IDLE && $urandom_range(0, 19) == 0) begin
                send_byte(8'($urandom_range(0, 255)), 1'b0, pick_address());
            end else begin
                send_random_instruction();
            end
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (decoded_insns.size() != 0) begin
            @(posedge aclk);
        end
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: x86_instruction_length_decoder.f
design/x86ild_pkg.sv
design/x86_instruction_length_decoder.sv
sim/x86_instruction_length_decoder_tb.sv
